@@ src/wtsa_pkg.sv @@
// Shared types, codes and constant tables for the weighted tier scheduler.
// No dependencies.
package wtsa_pkg;

	localparam int QUEUE_DEPTH_DEF = 16;
	localparam int TAG_BITS_DEF    = 32;
	localparam int STAMP_BITS_DEF  = 16;

	localparam int WEIGHT_BITS = 4;
	localparam int AGE_BITS    = 15;
	localparam int CFG_IDX_BITS = 2;
	localparam int CFG_DATA_BITS = 15;
	localparam int POS_BITS    = 6;
	localparam int OUT_CNT_BITS = 6;

	typedef enum logic [1:0] {
		OP_ENQ  = 2'd0,
		OP_DEQ  = 2'd1,
		OP_TICK = 2'd2,
		OP_NOP  = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		ST_ENQ   = 3'd0,
		ST_DROP  = 3'd1,
		ST_DEQ   = 3'd2,
		ST_EMPTY = 3'd3,
		ST_TICK  = 3'd4
	} st_t;

	localparam logic [1:0] TIER_CRIT = 2'd0;
	localparam logic [1:0] TIER_STD  = 2'd1;
	localparam logic [1:0] TIER_LOW  = 2'd2;

	localparam logic [1:0] REG_WCRIT = 2'd0;
	localparam logic [1:0] REG_WSTD  = 2'd1;
	localparam logic [1:0] REG_WLOW  = 2'd2;
	localparam logic [1:0] REG_AGE   = 2'd3;

	typedef struct packed {
		logic latch;
		logic enq;
		logic norm;
		logic walk;
		logic tick;
		logic prom_lo;
		logic prom_std;
	} cmd_t;

	typedef struct packed {
		op_t  op;
		logic total_zero;
		logic pos_ok;
		logic walk_hit;
		logic lo_can;
		logic std_can;
	} sts_t;

	typedef logic [3:0] tab_t [256];

	// gcd of two 4-bit values, index {a, b}
	function automatic tab_t build_gcd();
		tab_t r;
		int a;
		int b;
		for (int i = 0; i < 256; i++) begin
			a = i / 16;
			b = i % 16;
			while (b != 0) begin
				if (a >= b) a = a - b;
				else begin
					b = b - a;
					if (b == 0) b = 0;
				end
				if (a == 0) begin
					a = b;
					b = 0;
				end
			end
			r[i] = 4'(a);
		end
		return r;
	endfunction

	// quotient of 4-bit values, index {num, den}
	function automatic tab_t build_quo();
		tab_t r;
		int n;
		int d;
		int q;
		for (int i = 0; i < 256; i++) begin
			n = i / 16;
			d = i % 16;
			q = 0;
			if (d != 0) begin
				while (n >= d) begin
					n = n - d;
					q = q + 1;
				end
			end
			r[i] = 4'(q);
		end
		return r;
	endfunction

	localparam tab_t GCD_TAB = build_gcd();
	localparam tab_t QUO_TAB = build_quo();

endpackage

@@ src/wtsa_ctrl.sv @@
// Sequencing state machine for the tier scheduler.
// Depends on wtsa_pkg; drives commands into wtsa_dp.
module wtsa_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	input  wtsa_pkg::sts_t    sts,
	output wtsa_pkg::cmd_t    cmd
);
	import wtsa_pkg::*;

	typedef enum logic [9:0] {
		S_IDLE = 10'b0000000001,
		S_WAIT = 10'b0000000010,
		S_EXEC = 10'b0000000100,
		S_NORM = 10'b0000001000,
		S_WALK = 10'b0000010000,
		S_PL   = 10'b0000100000,
		S_PLW  = 10'b0001000000,
		S_PS   = 10'b0010000000,
		S_PSW  = 10'b0100000000,
		S_RESP = 10'b1000000000
	} state_t;

	state_t state_q, state_d;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = (state_q == S_RESP);

	always_comb begin
		state_d = state_q;
		cmd = '0;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.latch = 1'b1;
					state_d = S_WAIT;
				end
			end
			S_WAIT: state_d = S_EXEC;
			S_EXEC: begin
				case (sts.op)
					OP_ENQ: begin
						cmd.enq = 1'b1;
						state_d = S_RESP;
					end
					OP_DEQ: state_d = sts.total_zero ? S_RESP : S_NORM;
					OP_TICK: begin
						cmd.tick = 1'b1;
						state_d = S_PL;
					end
					default: state_d = S_RESP;
				endcase
			end
			S_NORM: begin
				if (sts.pos_ok) state_d = S_WALK;
				else cmd.norm = 1'b1;
			end
			S_WALK: begin
				cmd.walk = 1'b1;
				if (sts.walk_hit) state_d = S_RESP;
			end
			S_PL: begin
				if (sts.lo_can) begin
					cmd.prom_lo = 1'b1;
					state_d = S_PLW;
				end else state_d = S_PS;
			end
			S_PLW: state_d = S_PL;
			S_PS: begin
				if (sts.std_can) begin
					cmd.prom_std = 1'b1;
					state_d = S_PSW;
				end else state_d = S_RESP;
			end
			S_PSW: state_d = S_PS;
			S_RESP: if (out_ready) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else state_q <= state_d;
	end

endmodule

@@ src/wtsa_dp.sv @@
// Datapath: tier memories, queue pointers, schedule, tick and result registers.
// Depends on wtsa_pkg; commanded by wtsa_ctrl.
module wtsa_dp #(
	parameter int QUEUE_DEPTH = wtsa_pkg::QUEUE_DEPTH_DEF,
	parameter int TAG_BITS    = wtsa_pkg::TAG_BITS_DEF,
	parameter int STAMP_BITS  = wtsa_pkg::STAMP_BITS_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_we,
	input  logic [wtsa_pkg::CFG_IDX_BITS-1:0]     cfg_index,
	input  logic [wtsa_pkg::CFG_DATA_BITS-1:0]    cfg_data,
	input  logic [1:0]                            opcode,
	input  logic [1:0]                            tier_in,
	input  logic [TAG_BITS-1:0]                   tag_in,
	input  wtsa_pkg::cmd_t                        cmd,
	output wtsa_pkg::sts_t                        sts,
	output logic [2:0]                            status,
	output logic [TAG_BITS-1:0]                   tag_out,
	output logic [1:0]                            tier_out,
	output logic [wtsa_pkg::OUT_CNT_BITS-1:0]     promoted,
	output logic [wtsa_pkg::OUT_CNT_BITS-1:0]     occupancy
);
	import wtsa_pkg::*;

	localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CW = $clog2(QUEUE_DEPTH + 1);
	localparam int EW = TAG_BITS + STAMP_BITS;
	localparam int TW = CW + 2;
	localparam int CMPW = (STAMP_BITS > AGE_BITS) ? STAMP_BITS : AGE_BITS;

	logic [WEIGHT_BITS-1:0] wcrit_q, wstd_q, wlow_q;
	logic [AGE_BITS-1:0]    age_q;
	logic [WEIGHT_BITS-1:0] ra_q, rb_q, rc_q;
	logic [POS_BITS-1:0]    len_q, pos_q;
	logic [STAMP_BITS-1:0]  tick_q;

	op_t                    op_q;
	logic [1:0]             tier_q;
	logic [TAG_BITS-1:0]    tag_q;

	st_t                    status_q;
	logic [TAG_BITS-1:0]    tag_out_q;
	logic [1:0]             tier_out_q;
	logic [OUT_CNT_BITS-1:0] prom_q;

	logic [AW-1:0] head_q [3];
	logic [CW-1:0] cnt_q  [3];
	logic [EW-1:0] rd_q   [3];
	logic [EW-1:0] mem    [3][QUEUE_DEPTH];

	logic [AW-1:0] tail    [3];
	logic [AW-1:0] head_nx [3];
	logic [EW-1:0] wdat    [3];
	logic [2:0]    push, pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wcrit_q <= WEIGHT_BITS'(1);
			wstd_q  <= WEIGHT_BITS'(1);
			wlow_q  <= WEIGHT_BITS'(1);
			age_q   <= AGE_BITS'(40);
		end else if (cfg_we) begin
			case (cfg_index)
				REG_WCRIT: wcrit_q <= cfg_data[WEIGHT_BITS-1:0];
				REG_WSTD:  wstd_q  <= cfg_data[WEIGHT_BITS-1:0];
				REG_WLOW:  wlow_q  <= cfg_data[WEIGHT_BITS-1:0];
				REG_AGE:   age_q   <= cfg_data[AGE_BITS-1:0];
				default: ;
			endcase
		end
	end

	// schedule weights reduced by their common divisor
	logic [WEIGHT_BITS-1:0] wa, wb, wc, g1, g;
	always_comb begin
		wa = (wcrit_q == '0) ? WEIGHT_BITS'(1) : wcrit_q;
		wb = (wstd_q == '0) ? WEIGHT_BITS'(1) : wstd_q;
		wc = (wlow_q == '0) ? WEIGHT_BITS'(1) : wlow_q;
		g1 = GCD_TAB[{wa, wb}];
		g  = GCD_TAB[{g1, wc}];
	end

	always_ff @(posedge clk) begin
		ra_q  <= QUO_TAB[{wa, g}];
		rb_q  <= QUO_TAB[{wb, g}];
		rc_q  <= QUO_TAB[{wc, g}];
		len_q <= POS_BITS'(QUO_TAB[{wa, g}]) + POS_BITS'(QUO_TAB[{wb, g}])
			+ POS_BITS'(QUO_TAB[{wc, g}]);
	end

	// queue pointers
	logic [AW+1:0] tsum [3];
	always_comb begin
		for (int t = 0; t < 3; t++) begin
			tsum[t] = (AW+2)'(head_q[t]) + (AW+2)'(cnt_q[t]);
			tail[t] = (tsum[t] >= (AW+2)'(QUEUE_DEPTH)) ?
				AW'(tsum[t] - (AW+2)'(QUEUE_DEPTH)) : tsum[t][AW-1:0];
			head_nx[t] = (head_q[t] == AW'(QUEUE_DEPTH - 1)) ? '0 : head_q[t] + 1'b1;
		end
	end

	logic [TW-1:0] total;
	assign total = TW'(cnt_q[0]) + TW'(cnt_q[1]) + TW'(cnt_q[2]);

	// head aging
	logic [STAMP_BITS-1:0] age_lo, age_std;
	logic lo_aged, std_aged, enq_ok;
	always_comb begin
		age_lo  = tick_q - rd_q[2][STAMP_BITS-1:0];
		age_std = tick_q - rd_q[1][STAMP_BITS-1:0];
		lo_aged  = (cnt_q[2] != '0) && (CMPW'(age_lo) >= CMPW'(age_q));
		std_aged = (cnt_q[1] != '0) && (CMPW'(age_std) >= CMPW'(age_q));
		enq_ok = (tier_q != 2'd3) && (cnt_q[tier_q] != CW'(QUEUE_DEPTH));
	end

	// schedule walk
	logic [1:0]          t_walk;
	logic [POS_BITS-1:0] pos_nx;
	logic                walk_hit;
	always_comb begin
		if (pos_q < POS_BITS'(ra_q)) t_walk = TIER_CRIT;
		else if (pos_q < POS_BITS'(ra_q) + POS_BITS'(rb_q)) t_walk = TIER_STD;
		else t_walk = TIER_LOW;
		pos_nx = (pos_q + 1'b1 == len_q) ? '0 : pos_q + 1'b1;
		walk_hit = (cnt_q[t_walk] != '0);
	end

	assign sts.op         = op_q;
	assign sts.total_zero = (total == '0);
	assign sts.pos_ok     = (pos_q < len_q);
	assign sts.walk_hit   = walk_hit;
	assign sts.lo_can     = lo_aged && (cnt_q[1] != CW'(QUEUE_DEPTH));
	assign sts.std_can    = std_aged && (cnt_q[0] != CW'(QUEUE_DEPTH));

	always_comb begin
		push = '0;
		pop  = '0;
		for (int t = 0; t < 3; t++) wdat[t] = {tag_q, tick_q};
		if (cmd.enq && enq_ok) push[tier_q] = 1'b1;
		if (cmd.walk && walk_hit) pop[t_walk] = 1'b1;
		if (cmd.prom_lo && sts.lo_can) begin
			pop[2]  = 1'b1;
			push[1] = 1'b1;
			wdat[1] = {rd_q[2][EW-1:STAMP_BITS], tick_q};
		end
		if (cmd.prom_std && sts.std_can) begin
			pop[1]  = 1'b1;
			push[0] = 1'b1;
			wdat[0] = {rd_q[1][EW-1:STAMP_BITS], tick_q};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int t = 0; t < 3; t++) begin
				head_q[t] <= '0;
				cnt_q[t]  <= '0;
			end
		end else begin
			for (int t = 0; t < 3; t++) begin
				if (pop[t]) head_q[t] <= head_nx[t];
				if (push[t] && !pop[t]) cnt_q[t] <= cnt_q[t] + 1'b1;
				else if (pop[t] && !push[t]) cnt_q[t] <= cnt_q[t] - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int t = 0; t < 3; t++) begin
			if (push[t]) mem[t][tail[t]] <= wdat[t];
			rd_q[t] <= mem[t][head_q[t]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= '0;
			tick_q <= '0;
		end else begin
			if (cmd.norm) pos_q <= pos_q - len_q;
			else if (cmd.walk) pos_q <= pos_nx;
			if (cmd.tick) tick_q <= tick_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			op_q       <= op_t'(opcode);
			tier_q     <= tier_in;
			tag_q      <= tag_in;
			status_q   <= ST_EMPTY;
			tag_out_q  <= '0;
			tier_out_q <= '0;
			prom_q     <= '0;
		end else begin
			if (cmd.enq) status_q <= enq_ok ? ST_ENQ : ST_DROP;
			if (cmd.walk && walk_hit) begin
				status_q   <= ST_DEQ;
				tag_out_q  <= rd_q[t_walk][EW-1:STAMP_BITS];
				tier_out_q <= t_walk;
			end
			if (cmd.tick) status_q <= ST_TICK;
			if ((cmd.prom_lo && sts.lo_can) || (cmd.prom_std && sts.std_can))
				prom_q <= prom_q + 1'b1;
		end
	end

	assign status    = status_q;
	assign tag_out   = tag_out_q;
	assign tier_out  = tier_out_q;
	assign promoted  = prom_q;
	assign occupancy = OUT_CNT_BITS'(total);

endmodule

@@ src/weighted_tier_scheduler_with_aging.sv @@
// Top level of the weighted three-tier scheduler with aging.
// Depends on wtsa_pkg, wtsa_ctrl and wtsa_dp.
//
// Input channel (in_valid/in_ready) carries opcode, tier_in and tag_in:
// enqueue, dequeue or tick. Each transfer yields exactly one result on the
// output channel (out_valid/out_ready): status, tag_out, tier_out, promoted
// and occupancy. Configuration writes use cfg_valid/cfg_ready with cfg_index
// and cfg_data; cfg_ready is always high.
// One item is in flight at a time. An input transfer latches the item; a wait
// and an execute state follow. Enqueue, invalid opcode and empty dequeue then
// give the result; dequeue normalizes the schedule position, then walks slots
// until one hits a non-empty tier; tick promotes aged low heads to standard and
// then aged standard heads to critical, each promotion followed by a wait state.
// A new item is taken the cycle after the result transfer.
// Reset clears queue pointers, schedule position, tick count and restores
// the default weights and age limit; tier memories are not cleared.
// When the receiver stalls, the result holds and no input is taken.
module weighted_tier_scheduler_with_aging #(
	parameter int QUEUE_DEPTH = wtsa_pkg::QUEUE_DEPTH_DEF,
	parameter int TAG_BITS    = wtsa_pkg::TAG_BITS_DEF,
	parameter int STAMP_BITS  = wtsa_pkg::STAMP_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [wtsa_pkg::CFG_IDX_BITS-1:0]  cfg_index,
	input  logic [wtsa_pkg::CFG_DATA_BITS-1:0] cfg_data,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic [1:0]                         opcode,
	input  logic [1:0]                         tier_in,
	input  logic [TAG_BITS-1:0]                tag_in,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic [2:0]                         status,
	output logic [TAG_BITS-1:0]                tag_out,
	output logic [1:0]                         tier_out,
	output logic [wtsa_pkg::OUT_CNT_BITS-1:0]  promoted,
	output logic [wtsa_pkg::OUT_CNT_BITS-1:0]  occupancy
);
	import wtsa_pkg::*;

	cmd_t cmd;
	sts_t sts;

	assign cfg_ready = 1'b1;

	wtsa_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	wtsa_dp #(
		.QUEUE_DEPTH (QUEUE_DEPTH),
		.TAG_BITS    (TAG_BITS),
		.STAMP_BITS  (STAMP_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_valid & cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.opcode    (opcode),
		.tier_in   (tier_in),
		.tag_in    (tag_in),
		.cmd       (cmd),
		.sts       (sts),
		.status    (status),
		.tag_out   (tag_out),
		.tier_out  (tier_out),
		.promoted  (promoted),
		.occupancy (occupancy)
	);

endmodule

@@ src/wtsa_chk.sv @@
// Port-level checks for the tier scheduler, bound to the top level.
// Depends on wtsa_pkg and weighted_tier_scheduler_with_aging.
module wtsa_chk #(
	parameter int TAG_BITS = wtsa_pkg::TAG_BITS_DEF
) (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               in_valid,
	input logic                               in_ready,
	input logic                               out_valid,
	input logic                               out_ready,
	input logic [2:0]                         status,
	input logic [TAG_BITS-1:0]                tag_out,
	input logic [1:0]                         tier_out,
	input logic [wtsa_pkg::OUT_CNT_BITS-1:0]  promoted
);
	import wtsa_pkg::*;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

	a_one: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |-> !out_valid)
		else $error("input taken while result pending");

	a_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> status <= ST_TICK)
		else $error("bad status code");

	a_tag: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != ST_DEQ |-> tag_out == '0 && tier_out == '0)
		else $error("tag or tier set without dequeue");

	a_prom: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != ST_TICK |-> promoted == '0)
		else $error("promotion count outside tick");

endmodule

bind weighted_tier_scheduler_with_aging wtsa_chk #(.TAG_BITS(TAG_BITS)) u_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.status    (status),
	.tag_out   (tag_out),
	.tier_out  (tier_out),
	.promoted  (promoted)
);
